/* sv/triangle_unit_normal_assert.svh */
// ----------------------------------------------------------------------------
// Triangle unit normal assertion macros
// Shared concurrent assertion forms for the block checker.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_ASSERT_SVH

// same-cycle implication, masked during reset
`define TUN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("triangle unit normal assertion failed");

// next-cycle implication, masked during reset
`define TUN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("triangle unit normal assertion failed");

// state in the cycle after reset is applied
`define TUN_ASSERT_RST(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("triangle unit normal reset assertion failed");

`endif

/* sv/tun_pkg.sv */
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Default sizes and the side information carried along the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tun_pkg;

    localparam int CoordWidthDef    = 32;
    localparam int NormalFracDef    = 15;
    localparam int KeepBits         = 31;
    localparam int SumSqWidth       = 2 * KeepBits + 2;

    typedef struct packed {
        logic [2:0] neg;
        logic       deg;
    } t_side;

endpackage

/* sv/triangle_unit_normal.sv */
// Throughput: one triangle per cycle while o_stall is low, through the pipelined
// chain of one-bit digit cells.
// A two-entry output register and skid stage holds results under stall.
// Reset (synchronous, active low) empties the pipeline and the output stage.
// ----------------------------------------------------------------------------
// Triangle unit normal
// Cross product of two triangle edges scaled to unit length in fixed point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_unit_normal
    import tun_pkg::*;
#(
    parameter int COORD_WIDTH      = CoordWidthDef,
    parameter int NORMAL_FRAC_BITS = NormalFracDef
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [COORD_WIDTH-1:0]      i_ax,
    input  logic signed [COORD_WIDTH-1:0]      i_ay,
    input  logic signed [COORD_WIDTH-1:0]      i_az,
    input  logic signed [COORD_WIDTH-1:0]      i_bx,
    input  logic signed [COORD_WIDTH-1:0]      i_by_coord,
    input  logic signed [COORD_WIDTH-1:0]      i_bz,
    input  logic signed [COORD_WIDTH-1:0]      i_cx,
    input  logic signed [COORD_WIDTH-1:0]      i_cy,
    input  logic signed [COORD_WIDTH-1:0]      i_cz,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [NORMAL_FRAC_BITS+1:0] o_nx,
    output logic signed [NORMAL_FRAC_BITS+1:0] o_ny,
    output logic signed [NORMAL_FRAC_BITS+1:0] o_nz,
    output logic                               o_degenerate
);

    localparam int F  = NORMAL_FRAC_BITS;
    localparam int XW = 2 * (COORD_WIDTH + 1) + 1;
    localparam int SH = $clog2(XW - KeepBits + 1);
    localparam int OW = F + 2;
    localparam int QW = F + 1;
    localparam int SW = SumSqWidth;
    localparam int WT = 2 * F + SW + 7;
    localparam int P  = SH + F + 8;

    logic [P-1:0]         r_vld;
    logic                 w_en;

    logic [XW-1:0]        w_mag [SH+1][3];
    logic [XW-1:0]        w_acc [SH+1];
    t_side                w_sside [SH+1];

    logic [2*KeepBits-1:0] r_sq [3];
    t_side                 r_sq_side;
    logic [SW-1:0]         r_s;
    logic signed [WT-1:0]  r_rhs [3];
    t_side                 r_s_side;

    logic [SW-1:0]        w_s   [F+2];
    logic signed [WT-1:0] w_rhs [F+2][3];
    logic signed [WT-1:0] w_a   [F+2][3];
    logic signed [WT-1:0] w_b   [F+2][3];
    logic [QW-1:0]        w_q   [F+2][3];
    t_side                w_rside [F+2];

    logic signed [WT-1:0] w_s0;
    logic signed [OW-1:0] r_f_n [3];
    logic                 r_f_deg;
    logic signed [OW-1:0] n_f_n [3];
    logic [OW-1:0]        w_qx  [3];

    logic                 r_ov;
    logic                 r_sv;
    logic signed [OW-1:0] r_o_n [3];
    logic                 r_o_deg;
    logic signed [OW-1:0] r_k_n [3];
    logic                 r_k_deg;
    logic                 w_take;
    logic                 w_tail;

    assign w_en    = !r_sv;
    assign o_stall = r_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[P-2:0], i_valid};
        end
    end

    tun_cross #(.CW(COORD_WIDTH), .XW(XW)) u_cross (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_ax   (i_ax),
        .i_ay   (i_ay),
        .i_az   (i_az),
        .i_bx   (i_bx),
        .i_by   (i_by_coord),
        .i_bz   (i_bz),
        .i_cx   (i_cx),
        .i_cy   (i_cy),
        .i_cz   (i_cz),
        .o_mag  (w_mag[0]),
        .o_acc  (w_acc[0]),
        .o_side (w_sside[0])
    );

    for (genvar g = 0; g < SH; g++) begin : g_shift
        tun_shift_cell #(.W(XW), .KEEP(KeepBits), .SHAMT(1 << (SH - 1 - g))) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_mag  (w_mag[g]),
            .i_acc  (w_acc[g]),
            .i_side (w_sside[g]),
            .o_mag  (w_mag[g+1]),
            .o_acc  (w_acc[g+1]),
            .o_side (w_sside[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i]  <= w_mag[SH][i][KeepBits-1:0] * w_mag[SH][i][KeepBits-1:0];
                r_rhs[i] <= $signed(WT'(r_sq[i])) <<< (2 * F + 2);
            end
            r_sq_side <= w_sside[SH];
            r_s       <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
            r_s_side  <= r_sq_side;
        end
    end

    assign w_s0       = $signed({{(WT-SW){1'b0}}, r_s});
    assign w_s[0]     = r_s;
    assign w_rside[0] = r_s_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rhs[0][i] = r_rhs[i];
            w_a[0][i]   = w_s0;
            w_b[0][i]   = -w_s0;
            w_q[0][i]   = '0;
        end
    end

    for (genvar g = 0; g <= F; g++) begin : g_root
        tun_root_cell #(.SW(SW), .WT(WT), .QW(QW), .BIT(F - g)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_s    (w_s[g]),
            .i_rhs  (w_rhs[g]),
            .i_a    (w_a[g]),
            .i_b    (w_b[g]),
            .i_q    (w_q[g]),
            .i_side (w_rside[g]),
            .o_s    (w_s[g+1]),
            .o_rhs  (w_rhs[g+1]),
            .o_a    (w_a[g+1]),
            .o_b    (w_b[g+1]),
            .o_q    (w_q[g+1]),
            .o_side (w_rside[g+1])
        );
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_qx[i] = {1'b0, w_q[F+1][i]};
            if (w_rside[F+1].deg) begin
                n_f_n[i] = '0;
            end else if (w_rside[F+1].neg[i]) begin
                n_f_n[i] = $signed(~w_qx[i] + OW'(1));
            end else begin
                n_f_n[i] = $signed(w_qx[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_n   <= n_f_n;
            r_f_deg <= w_rside[F+1].deg;
        end
    end

    assign w_take = r_ov && !i_stall;
    assign w_tail = r_vld[P-1] && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (w_take) begin
                r_sv <= 1'b0;
            end
        end else if (w_tail) begin
            if (r_ov && !w_take) begin
                r_sv <= 1'b1;
            end else begin
                r_ov <= 1'b1;
            end
        end else if (w_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (w_take) begin
                r_o_n   <= r_k_n;
                r_o_deg <= r_k_deg;
            end
        end else if (w_tail) begin
            if (r_ov && !w_take) begin
                r_k_n   <= r_f_n;
                r_k_deg <= r_f_deg;
            end else begin
                r_o_n   <= r_f_n;
                r_o_deg <= r_f_deg;
            end
        end
    end

    assign o_valid      = r_ov;
    assign o_nx         = r_o_n[0];
    assign o_ny         = r_o_n[1];
    assign o_nz         = r_o_n[2];
    assign o_degenerate = r_o_deg;

endmodule

/* sv/tun_cross.sv */
// ----------------------------------------------------------------------------
// Triangle unit normal cross product front end
// Edges, six exact products, cross components and their magnitudes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tun_cross
    import tun_pkg::*;
#(
    parameter int CW = CoordWidthDef,
    parameter int XW = 2 * (CW + 1) + 1
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_ax,
    input  logic signed [CW-1:0] i_ay,
    input  logic signed [CW-1:0] i_az,
    input  logic signed [CW-1:0] i_bx,
    input  logic signed [CW-1:0] i_by,
    input  logic signed [CW-1:0] i_bz,
    input  logic signed [CW-1:0] i_cx,
    input  logic signed [CW-1:0] i_cy,
    input  logic signed [CW-1:0] i_cz,
    output logic [XW-1:0]        o_mag [3],
    output logic [XW-1:0]        o_acc,
    output t_side                o_side
);

    localparam int EW = CW + 1;
    localparam int PW = 2 * EW;

    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic signed [PW-1:0] r_p  [6];
    logic signed [XW-1:0] r_c  [3];
    logic [XW-1:0]        r_mag [3];
    logic [XW-1:0]        r_acc;
    t_side                r_side;

    logic [XW-1:0]        n_mag [3];
    logic [XW-1:0]        n_acc;
    logic [XW-1:0]        w_cu  [3];
    logic [2:0]           n_neg;

    always_comb begin
        n_acc = '0;
        for (int i = 0; i < 3; i++) begin
            w_cu[i]  = r_c[i];
            n_neg[i] = w_cu[i][XW-1];
            n_mag[i] = n_neg[i] ? (~w_cu[i] + XW'(1)) : w_cu[i];
            n_acc    = n_acc | n_mag[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e1[0] <= $signed({i_ax[CW-1], i_ax}) - $signed({i_bx[CW-1], i_bx});
            r_e1[1] <= $signed({i_ay[CW-1], i_ay}) - $signed({i_by[CW-1], i_by});
            r_e1[2] <= $signed({i_az[CW-1], i_az}) - $signed({i_bz[CW-1], i_bz});
            r_e2[0] <= $signed({i_ax[CW-1], i_ax}) - $signed({i_cx[CW-1], i_cx});
            r_e2[1] <= $signed({i_ay[CW-1], i_ay}) - $signed({i_cy[CW-1], i_cy});
            r_e2[2] <= $signed({i_az[CW-1], i_az}) - $signed({i_cz[CW-1], i_cz});
            r_p[0]  <= r_e1[1] * r_e2[2];
            r_p[1]  <= r_e2[1] * r_e1[2];
            r_p[2]  <= r_e2[0] * r_e1[2];
            r_p[3]  <= r_e1[0] * r_e2[2];
            r_p[4]  <= r_e1[0] * r_e2[1];
            r_p[5]  <= r_e2[0] * r_e1[1];
            r_c[0]  <= $signed({r_p[0][PW-1], r_p[0]}) - $signed({r_p[1][PW-1], r_p[1]});
            r_c[1]  <= $signed({r_p[2][PW-1], r_p[2]}) - $signed({r_p[3][PW-1], r_p[3]});
            r_c[2]  <= $signed({r_p[4][PW-1], r_p[4]}) - $signed({r_p[5][PW-1], r_p[5]});
            r_mag   <= n_mag;
            r_acc   <= n_acc;
            r_side.neg <= n_neg;
            r_side.deg <= (n_acc == '0);
        end
    end

    assign o_mag  = r_mag;
    assign o_acc  = r_acc;
    assign o_side = r_side;

endmodule

/* sv/tun_shift_cell.sv */
// ----------------------------------------------------------------------------
// Triangle unit normal shift cell
// One binary step of the right shift that brings the magnitudes to 31 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tun_shift_cell
    import tun_pkg::*;
#(
    parameter int W     = 67,
    parameter int KEEP  = KeepBits,
    parameter int SHAMT = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_mag [3],
    input  logic [W-1:0] i_acc,
    input  t_side        i_side,
    output logic [W-1:0] o_mag [3],
    output logic [W-1:0] o_acc,
    output t_side        o_side
);

    logic [W-1:0] r_mag [3];
    logic [W-1:0] r_acc;
    t_side        r_side;
    logic         w_big;

    assign w_big = (i_acc >> (KEEP + SHAMT - 1)) != '0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_mag[i] <= w_big ? (i_mag[i] >> SHAMT) : i_mag[i];
            end
            r_acc  <= w_big ? (i_acc >> SHAMT) : i_acc;
            r_side <= i_side;
        end
    end

    assign o_mag  = r_mag;
    assign o_acc  = r_acc;
    assign o_side = r_side;

endmodule

/* sv/tun_root_cell.sv */
// ----------------------------------------------------------------------------
// Triangle unit normal digit cell
// Decide one bit of each normal magnitude by an exact square compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tun_root_cell
    import tun_pkg::*;
#(
    parameter int SW  = SumSqWidth,
    parameter int WT  = 101,
    parameter int QW  = 16,
    parameter int BIT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [SW-1:0]        i_s,
    input  logic signed [WT-1:0] i_rhs [3],
    input  logic signed [WT-1:0] i_a   [3],
    input  logic signed [WT-1:0] i_b   [3],
    input  logic [QW-1:0]        i_q   [3],
    input  t_side                i_side,
    output logic [SW-1:0]        o_s,
    output logic signed [WT-1:0] o_rhs [3],
    output logic signed [WT-1:0] o_a   [3],
    output logic signed [WT-1:0] o_b   [3],
    output logic [QW-1:0]        o_q   [3],
    output t_side                o_side
);

    logic [SW-1:0]        r_s;
    logic signed [WT-1:0] r_rhs [3];
    logic signed [WT-1:0] r_a   [3];
    logic signed [WT-1:0] r_b   [3];
    logic [QW-1:0]        r_q   [3];
    t_side                r_side;

    logic signed [WT-1:0] w_sx;
    logic signed [WT-1:0] w_try [3];
    logic [2:0]           w_ok;

    assign w_sx = $signed({{(WT-SW){1'b0}}, i_s});

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_try[i] = i_a[i] + (i_b[i] <<< (BIT + 2)) + (w_sx <<< (2 * BIT + 2));
            w_ok[i]  = w_try[i] <= i_rhs[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= w_ok[i] ? w_try[i] : i_a[i];
                r_b[i] <= w_ok[i] ? (i_b[i] + (w_sx <<< (BIT + 1))) : i_b[i];
                r_q[i] <= w_ok[i] ? (i_q[i] | (QW'(1) << BIT)) : i_q[i];
            end
            r_s    <= i_s;
            r_rhs  <= i_rhs;
            r_side <= i_side;
        end
    end

    assign o_s    = r_s;
    assign o_rhs  = r_rhs;
    assign o_a    = r_a;
    assign o_b    = r_b;
    assign o_q    = r_q;
    assign o_side = r_side;

endmodule

/* sv/tun_checker.sv */
// ----------------------------------------------------------------------------
// Triangle unit normal checker
// Port-level assertions on the output stage, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "triangle_unit_normal_assert.svh"

module tun_checker #(
    parameter int OW = 17
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input logic [OW-1:0] o_nx,
    input logic [OW-1:0] o_ny,
    input logic [OW-1:0] o_nz,
    input logic          o_degenerate
);

    localparam logic [OW-1:0] MostNeg = {1'b1, {(OW-1){1'b0}}};

    `TUN_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_nx) && $stable(o_degenerate))
    `TUN_ASSERT_IMP(a_degen, i_clk, i_rst_n, o_valid && o_degenerate, o_nx == '0 && o_ny == '0 && o_nz == '0)
    `TUN_ASSERT_IMP(a_range, i_clk, i_rst_n, o_valid, o_nx != MostNeg && o_ny != MostNeg && o_nz != MostNeg)
    `TUN_ASSERT_IMP(a_skid, i_clk, i_rst_n, o_stall, o_valid)
    `TUN_ASSERT_RST(a_rst, i_clk, i_rst_n, !o_valid && !o_stall)

endmodule

bind triangle_unit_normal tun_checker #(.OW(NORMAL_FRAC_BITS + 2)) u_tun_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_nx         (o_nx),
    .o_ny         (o_ny),
    .o_nz         (o_nz),
    .o_degenerate (o_degenerate)
);

/* verif/triangle_unit_normal_tb.sv */
// ----------------------------------------------------------------------------
// Triangle unit normal testbench
// Streams triangles through the block with random gaps on both sides and a
// long receiver hold-off. A directed table covers degenerate, axis-aligned and
// full-range triangles. Random triangles follow: full-range, small, mesh-like,
// collinear and extreme. Every normal is checked against the table's expected value
// or an exact predictor built on 128-bit integer arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_unit_normal_tb;
    import tun_pkg::*;

    localparam int NUM_DIR    = 13;
    localparam int NUM_ITEMS  = 1650;
    localparam int WDOG_LIMIT = 4000;
    localparam int HOLD_START = 1500;
    localparam int HOLD_LEN   = 400;
    localparam int QUIET_LO   = 300;
    localparam int QUIET_HI   = 900;
    localparam int DRAIN      = 60;

    localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] CMIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;
    localparam logic signed [16:0] UNIT = 17'sd32768;

    typedef struct packed {
        logic signed [31:0] ax, ay, az, bx, by_coord, bz, cx, cy, cz;
        logic               chk;
        logic signed [16:0] nx, ny, nz;
        logic               deg;
    } tri_row_t;

    typedef struct packed {
        logic signed [16:0] nx, ny, nz;
        logic               deg;
    } normal_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    logic signed [31:0] i_ax = '0, i_ay = '0, i_az = '0;
    logic signed [31:0] i_bx = '0, i_by_coord = '0, i_bz = '0;
    logic signed [31:0] i_cx = '0, i_cy = '0, i_cz = '0;
    logic               o_stall, o_valid, o_degenerate;
    logic signed [16:0] o_nx, o_ny, o_nz;

    tri_row_t directed [NUM_DIR];
    tri_row_t cur_row;
    normal_t  normal_q [$];
    int       n_issued = 0, n_sent = 0, n_recv = 0, n_deg = 0;
    int       errors = 0, cyc = 0, idle_cnt = 0;

    triangle_unit_normal i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_ax         (i_ax),
        .i_ay         (i_ay),
        .i_az         (i_az),
        .i_bx         (i_bx),
        .i_by_coord   (i_by_coord),
        .i_bz         (i_bz),
        .i_cx         (i_cx),
        .i_cy         (i_cy),
        .i_cz         (i_cz),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_nx         (o_nx),
        .o_ny         (o_ny),
        .o_nz         (o_nz),
        .o_degenerate (o_degenerate)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic normal_t predict_normal(input tri_row_t r);
        logic signed [63:0]  e1 [3];
        logic signed [63:0]  e2 [3];
        logic signed [127:0] cr [3];
        logic [127:0]        mg [3];
        logic [127:0]        acc, lhs, rhs;
        logic [63:0]         m [3];
        logic [63:0]         ssq;
        logic [127:0]        t, d;
        logic [16:0]         q;
        logic signed [16:0]  comp [3];
        int                  len, sh;
        normal_t             n;
        e1[0] = r.ax - r.bx;
        e1[1] = r.ay - r.by_coord;
        e1[2] = r.az - r.bz;
        e2[0] = r.ax - r.cx;
        e2[1] = r.ay - r.cy;
        e2[2] = r.az - r.cz;
        cr[0] = e1[1] * e2[2] - e2[1] * e1[2];
        cr[1] = e2[0] * e1[2] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e2[0] * e1[1];
        acc = '0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = cr[i][127] ? -cr[i] : cr[i];
            acc |= mg[i];
        end
        len = 0;
        for (int i = 0; i < 128; i++) begin
            if (acc[i]) len = i + 1;
        end
        if (len == 0) begin
            n = '{nx: '0, ny: '0, nz: '0, deg: 1'b1};
            return n;
        end
        sh = (len > KeepBits) ? len - KeepBits : 0;
        ssq = '0;
        for (int i = 0; i < 3; i++) begin
            m[i] = 64'(mg[i] >> sh);
            ssq += m[i] * m[i];
        end
        for (int i = 0; i < 3; i++) begin
            rhs = (128'(m[i]) * 128'(m[i])) << 32;
            q = '0;
            for (int b = 15; b >= 0; b--) begin
                t = 128'(q) | (128'd1 << b);
                d = 2 * t - 1;
                lhs = d * d * 128'(ssq);
                if (lhs <= rhs) q = 17'(t);
            end
            comp[i] = cr[i][127] ? -$signed(q) : $signed(q);
        end
        n = '{nx: comp[0], ny: comp[1], nz: comp[2], deg: 1'b0};
        return n;
    endfunction

    function automatic logic signed [31:0] small_coord(input int span);
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(3))
            0: return CMAX;
            1: return CMIN;
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic tri_row_t make_triangle(input int idx);
        tri_row_t r;
        logic signed [31:0] dx, dy, dz;
        int k;
        if (idx < NUM_DIR) return directed[idx];
        r = '0;
        case ($urandom_range(9))
            0, 1, 2: begin
                {r.ax, r.ay, r.az} = {$urandom, $urandom, $urandom};
                {r.bx, r.by_coord, r.bz} = {$urandom, $urandom, $urandom};
                {r.cx, r.cy, r.cz} = {$urandom, $urandom, $urandom};
            end
            3, 4: begin
                {r.ax, r.ay, r.az} = {small_coord(1 << 20), small_coord(1 << 20),
                                      small_coord(1 << 20)};
                {r.bx, r.by_coord, r.bz} = {small_coord(1 << 20), small_coord(1 << 20),
                                            small_coord(1 << 20)};
                {r.cx, r.cy, r.cz} = {small_coord(1 << 20), small_coord(1 << 20),
                                      small_coord(1 << 20)};
            end
            5: begin
                {r.ax, r.ay, r.az} = {$urandom, $urandom, $urandom};
                dx = small_coord(1 << 18);
                dy = small_coord(1 << 18);
                dz = small_coord(1 << 18);
                k = $urandom_range(0, 4) - 2;
                r.bx = r.ax + dx; r.by_coord = r.ay + dy; r.bz = r.az + dz;
                r.cx = r.ax + k * dx; r.cy = r.ay + k * dy; r.cz = r.az + k * dz;
            end
            6: begin
                {r.ax, r.ay, r.az} = {pick_extreme(), pick_extreme(), pick_extreme()};
                {r.bx, r.by_coord, r.bz} = {pick_extreme(), pick_extreme(), pick_extreme()};
                {r.cx, r.cy, r.cz} = {pick_extreme(), pick_extreme(), pick_extreme()};
            end
            default: begin
                {r.ax, r.ay, r.az} = {$urandom, $urandom, $urandom};
                k = 1 << $urandom_range(2, 24);
                r.bx = r.ax + small_coord(k);
                r.by_coord = r.ay + small_coord(k);
                r.bz = r.az + small_coord(k);
                r.cx = r.ax + small_coord(k);
                r.cy = r.ay + small_coord(k);
                r.cz = r.az + small_coord(k);
            end
        endcase
        return r;
    endfunction

    function automatic bit sender_idle();
        if (cyc >= QUIET_LO && cyc < QUIET_HI) return 1'b0;
        return $urandom_range(99) < 19;
    endfunction

    // sender: record each accepted beat, then offer the next triangle
    always @(posedge i_clk) begin
        tri_row_t nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                normal_q.push_back(cur_row.chk ? normal_t'{cur_row.nx, cur_row.ny,
                                   cur_row.nz, cur_row.deg} : predict_normal(cur_row));
                n_sent <= n_sent + 1;
            end
            if (!i_valid || !o_stall) begin
                if (n_issued < NUM_ITEMS && !sender_idle()) begin
                    nxt = make_triangle(n_issued);
                    cur_row <= nxt;
                    n_issued <= n_issued + 1;
                    i_valid <= 1'b1;
                    {i_ax, i_ay, i_az} <= {nxt.ax, nxt.ay, nxt.az};
                    {i_bx, i_by_coord, i_bz} <= {nxt.bx, nxt.by_coord, nxt.bz};
                    {i_cx, i_cy, i_cz} <= {nxt.cx, nxt.cy, nxt.cz};
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: hold off for a long stretch once, never stall in the quiet window, otherwise stall at random
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) i_stall <= 1'b1;
        else if (cyc >= QUIET_LO && cyc < QUIET_HI) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < 19);
    end

    always @(posedge i_clk) begin
        normal_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_recv <= n_recv + 1;
            if (normal_q.size() == 0) begin
                $display("%0t: unexpected normal nx=%0d ny=%0d nz=%0d deg=%0b",
                         $time, o_nx, o_ny, o_nz, o_degenerate);
                errors++;
            end else begin
                want = normal_q.pop_front();
                if (want.deg) n_deg <= n_deg + 1;
                if (o_nx !== want.nx) begin
                    $display("%0t: nx expected %0d actual %0d", $time, want.nx, o_nx);
                    errors++;
                end
                if (o_ny !== want.ny) begin
                    $display("%0t: ny expected %0d actual %0d", $time, want.ny, o_ny);
                    errors++;
                end
                if (o_nz !== want.nz) begin
                    $display("%0t: nz expected %0d actual %0d", $time, want.nz, o_nz);
                    errors++;
                end
                if (o_degenerate !== want.deg) begin
                    $display("%0t: degenerate expected %0b actual %0b",
                             $time, want.deg, o_degenerate);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= WDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_cnt);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    initial begin
        directed = '{
            '{'0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1, '0, '0, '0, 1'b1},
            '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
              1'b1, '0, '0, '0, 1'b1},
            '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
              1'b1, '0, '0, '0, 1'b1},
            '{'0, '0, '0, -ONE, '0, '0, '0, -ONE, '0, 1'b1, '0, '0, UNIT, 1'b0},
            '{'0, '0, '0, '0, -ONE, '0, -ONE, '0, '0, 1'b1, '0, '0, -UNIT, 1'b0},
            '{'0, '0, '0, '0, -ONE, '0, '0, '0, -ONE, 1'b1, UNIT, '0, '0, 1'b0},
            '{'0, '0, '0, '0, '0, -ONE, -ONE, '0, '0, 1'b1, '0, UNIT, '0, 1'b0},
            '{ONE, 2 * ONE, 3 * ONE, 2 * ONE, 4 * ONE, 6 * ONE, 3 * ONE, 6 * ONE,
              9 * ONE, 1'b1, '0, '0, '0, 1'b1},
            '{'0, '0, '0, 32'sd1, '0, '0, '0, 32'sd1, '0, 1'b1, '0, '0, UNIT, 1'b0},
            '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN,
              1'b0, '0, '0, '0, 1'b0},
            '{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN,
              1'b0, '0, '0, '0, 1'b0},
            '{CMAX, CMIN, CMAX, '0, '0, '0, CMIN, CMAX, '0, 1'b0, '0, '0, '0, 1'b0},
            '{'0, '0, '0, ONE, ONE, '0, '0, ONE, ONE, 1'b0, '0, '0, '0, 1'b0}
        };
        cur_row = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (n_sent < NUM_ITEMS) @(posedge i_clk);
        while (normal_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        $display("Sent %0d triangles (%0d directed, rest random), %0d normals checked",
                 n_sent, NUM_DIR, n_recv);
        $display("Degenerate triangles seen: %0d, receiver hold-off of %0d cycles",
                 n_deg, HOLD_LEN);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
